// ===== hw/rtl/rdu_pkg.sv =====
// Shared constants for the refraction direction unit.
package rdu_pkg;

    localparam int VEC_FRAC_BITS_DEF = 14;

    localparam int ETA_W      = 19;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (ETA_W + DIV_STEP - 1) / DIV_STEP;

    localparam int C2_W      = 29;
    localparam int SQ_W      = 23;
    localparam int SQ_RAD_W  = 2 * SQ_W;
    localparam int SQ_REM_W  = SQ_W + 3;
    localparam int SQ_STEP   = 4;
    localparam int SQ_STAGES = (SQ_W + SQ_STEP - 1) / SQ_STEP;

    localparam int SIDE_LEN = DIV_STAGES + 3 + SQ_STAGES + 1;
    localparam int LATENCY  = SIDE_LEN + 4;

    localparam logic [1:0] MC_OUTSIDE    = 2'd0;
    localparam logic [1:0] MC_INSIDE_HIT = 2'd1;

    localparam logic [15:0] ONE_Q13    = 16'd8192;
    localparam logic [15:0] WEIGHT_ONE = 16'h8000;

endpackage

// ===== hw/rtl/rdu_div.sv =====
// Pipelined restoring divider for the relative index, saturated quotient.
module rdu_div (
    input  logic                      clk,
    input  logic [15:0]               num,
    input  logic [15:0]               den,
    output logic [rdu_pkg::ETA_W-1:0] quot
);

    localparam int BITS   = rdu_pkg::ETA_W;
    localparam int STEP   = rdu_pkg::DIV_STEP;
    localparam int STAGES = rdu_pkg::DIV_STAGES;

    logic [15:0]     rem_reg [0:STAGES-2];
    logic [15:0]     den_reg [0:STAGES-2];
    logic [BITS-1:0] low_reg [0:STAGES-2];
    logic [BITS-1:0] quo_reg [0:STAGES-1];
    logic            sat_reg [0:STAGES-1];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [15:0]     rem_src;
        logic [15:0]     den_src;
        logic [BITS-1:0] low_src;
        logic [BITS-1:0] quo_src;
        logic            sat_src;
        logic [15:0]     rem_next;
        logic [BITS-1:0] low_next;
        logic [BITS-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_src = {3'b000, num[15:3]};
            assign den_src = den;
            assign low_src = {num[2:0], {(BITS - 3){1'b0}}};
            assign quo_src = '0;
            assign sat_src = ({3'b000, num} >= {den, 3'b000});
        end
        else
        begin : g_next
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign low_src = low_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign sat_src = sat_reg[k-1];
        end

        always_comb
        begin
            logic [16:0]     r;
            logic [BITS-1:0] lo;
            logic [BITS-1:0] q;
            r  = {1'b0, rem_src};
            lo = low_src;
            q  = quo_src;
            for (int j = 0; j < STEP; j++)
            begin
                if (k * STEP + j < BITS)
                begin
                    r  = {r[15:0], lo[BITS-1]};
                    lo = {lo[BITS-2:0], 1'b0};
                    q  = {q[BITS-2:0], 1'b0};
                    if (r >= {1'b0, den_src})
                    begin
                        r    = r - {1'b0, den_src};
                        q[0] = 1'b1;
                    end
                end
            end
            rem_next = r[15:0];
            low_next = lo;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next;
            sat_reg[k] <= sat_src;
        end

        if (k < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_src;
                low_reg[k] <= low_next;
            end
        end
    end

    assign quot = sat_reg[STAGES-1] ? {BITS{1'b1}} : quo_reg[STAGES-1];

endmodule

// ===== hw/rtl/rdu_sqrt.sv =====
// Pipelined digit-by-digit integer square root of c2 scaled by 2^16.
module rdu_sqrt (
    input  logic                     clk,
    input  logic [rdu_pkg::C2_W-1:0] c2,
    output logic [rdu_pkg::SQ_W-1:0] root
);

    localparam int BITS   = rdu_pkg::SQ_W;
    localparam int RAD_W  = rdu_pkg::SQ_RAD_W;
    localparam int REM_W  = rdu_pkg::SQ_REM_W;
    localparam int STEP   = rdu_pkg::SQ_STEP;
    localparam int STAGES = rdu_pkg::SQ_STAGES;
    localparam int C2W    = rdu_pkg::C2_W;

    logic [REM_W-1:0] rem_reg  [0:STAGES-2];
    logic [RAD_W-1:0] rad_reg  [0:STAGES-2];
    logic [BITS-1:0]  root_reg [0:STAGES-1];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_src;
        logic [RAD_W-1:0] rad_src;
        logic [BITS-1:0]  root_src;
        logic [REM_W-1:0] rem_next;
        logic [RAD_W-1:0] rad_next;
        logic [BITS-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign rem_src  = '0;
            assign rad_src  = {{(RAD_W - C2W - 16){1'b0}}, c2, 16'h0000};
            assign root_src = '0;
        end
        else
        begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign root_src = root_reg[k-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] r;
            logic [REM_W-1:0] trial;
            logic [RAD_W-1:0] rd;
            logic [BITS-1:0]  q;
            r  = rem_src;
            rd = rad_src;
            q  = root_src;
            for (int j = 0; j < STEP; j++)
            begin
                if (k * STEP + j < BITS)
                begin
                    r     = {r[REM_W-3:0], rd[RAD_W-1:RAD_W-2]};
                    rd    = {rd[RAD_W-3:0], 2'b00};
                    trial = {1'b0, q, 2'b01};
                    if (r >= trial)
                    begin
                        r = r - trial;
                        q = {q[BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[BITS-2:0], 1'b0};
                    end
                end
            end
            rem_next  = r;
            rad_next  = rd;
            root_next = q;
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= root_next;
        end

        if (k < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                rad_reg[k] <= rad_next;
            end
        end
    end

    assign root = root_reg[STAGES-1];

endmodule

// ===== hw/rtl/refraction_direction_unit.sv =====
// Top level: Snell refraction with total internal reflection, fixed point.
// Done: the strobe follows start through the s1, s2 and s3 stages, the side pipeline and the done register.
// Throughput: one transaction per cycle; busy stays low, every stage advances each cycle.
// The depth is set by the 5-stage index divider and the 6-stage square root unit.
// Reset: rst_n clears all valid bits at once; no result is produced from reset state.
module refraction_direction_unit #(
    parameter int VEC_FRAC_BITS = rdu_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        ray_weight,
    input  logic [1:0]         medium_case,
    input  logic [15:0]        hit_ior,
    input  logic [15:0]        outer_ior,
    input  logic [15:0]        source_ior,
    input  logic [15:0]        transmit_factor,
    output logic               done,
    output logic signed [15:0] new_dir_x,
    output logic signed [15:0] new_dir_y,
    output logic signed [15:0] new_dir_z,
    output logic [15:0]        new_weight,
    output logic               ray_kind,
    output logic               now_outside
);

    localparam int ETA_W    = rdu_pkg::ETA_W;
    localparam int SQ_W     = rdu_pkg::SQ_W;
    localparam int C2_W     = rdu_pkg::C2_W;
    localparam int SIDE_LEN = rdu_pkg::SIDE_LEN;
    localparam int IDX_ETA  = rdu_pkg::DIV_STAGES;
    localparam int IDX_C2   = IDX_ETA + 2;
    localparam int IDX_F1   = SIDE_LEN - 1;
    localparam int IDX_SQ   = IDX_F1 - 1;
    localparam int C1_SH    = 2 * VEC_FRAC_BITS - 16;
    localparam int RFL_W    = (2 * VEC_FRAC_BITS + 2 > 51) ? 2 * VEC_FRAC_BITS + 2 : 51;
    localparam logic [RFL_W-1:0] RFL_RND =
        {{(RFL_W - 1){1'b0}}, 1'b1} << (2 * VEC_FRAC_BITS - 1);

    typedef struct packed {
        logic [2:0][15:0] d;
        logic [2:0][16:0] np;
        logic [2:0][15:0] refl;
        logic [15:0]      wout;
        logic [18:0]      c1;
        logic [ETA_W-1:0] eta;
        logic [21:0]      w;
        logic             refr;
        logic             flag_refr;
        logic             flag_tir;
    } side_t;

    logic accept;

    logic             s1_vld_reg;
    logic [2:0][15:0] s1_d_reg;
    logic [2:0][15:0] s1_n_reg;
    logic [15:0]      s1_weight_reg;
    logic [15:0]      s1_kt_reg;
    logic [1:0]       s1_mcase_reg;
    logic [15:0]      s1_hit_reg;
    logic [15:0]      s1_outer_reg;
    logic [15:0]      s1_src_reg;

    logic             s2_vld_reg;
    logic [2:0][31:0] s2_p_reg;
    logic [31:0]      s2_wprod_reg;
    logic [2:0][15:0] s2_d_reg;
    logic [2:0][15:0] s2_n_reg;
    logic [1:0]       s2_mcase_reg;
    logic [15:0]      s2_hit_reg;
    logic [15:0]      s2_outer_reg;
    logic [15:0]      s2_src_reg;

    logic             s3_vld_reg;
    logic [31:0]      s3_c1mag_reg;
    logic             s3_front_reg;
    logic [2:0][16:0] s3_np_reg;
    logic [2:0][15:0] s3_d_reg;
    logic [15:0]      s3_wout_reg;
    logic [1:0]       s3_mcase_reg;
    logic [15:0]      s3_hit_reg;
    logic [15:0]      s3_outer_reg;
    logic [15:0]      s3_src_reg;

    logic [33:0]      s3_dot_next;
    logic [16:0]      s3_wsh_next;

    logic [15:0]      div_num;
    logic [15:0]      div_den;
    logic [ETA_W-1:0] div_quot;

    logic [2:0][49:0] refl_prod_reg;
    logic [2:0][15:0] refl_val;

    side_t side_reg  [0:SIDE_LEN-1];
    side_t side_next [0:SIDE_LEN-1];
    logic  vld_reg   [0:SIDE_LEN-1];

    logic [37:0]        w_full;
    logic signed [47:0] prod_reg;
    logic signed [47:0] prod_next;
    logic signed [47:0] c2_full;
    logic [C2_W-1:0]    c2_reg;
    logic [SQ_W-1:0]    sq_root;

    logic [2:0][35:0] m1_reg;
    logic [2:0][40:0] m2_reg;
    logic [2:0][35:0] m1_next;
    logic [2:0][40:0] m2_next;
    logic [2:0][15:0] refr_val;

    logic             done_reg;
    logic [2:0][15:0] dir_out_reg;
    logic [15:0]      weight_out_reg;
    logic             kind_reg;
    logic             outside_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            for (int k = 0; k < SIDE_LEN; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            vld_reg[0] <= s3_vld_reg;
            for (int k = 1; k < SIDE_LEN; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            done_reg <= vld_reg[SIDE_LEN-1];
        end
    end

    // capture the transaction
    always_ff @(posedge clk)
    begin
        s1_d_reg      <= {dir_z, dir_y, dir_x};
        s1_n_reg      <= {normal_z, normal_y, normal_x};
        s1_weight_reg <= ray_weight;
        s1_kt_reg     <= transmit_factor;
        s1_mcase_reg  <= medium_case;
        s1_hit_reg    <= hit_ior;
        s1_outer_reg  <= outer_ior;
        s1_src_reg    <= source_ior;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_p_reg[i] <= $signed(s1_d_reg[i]) * $signed(s1_n_reg[i]);
        end
        s2_wprod_reg <= s1_weight_reg * s1_kt_reg;
        s2_d_reg     <= s1_d_reg;
        s2_n_reg     <= s1_n_reg;
        s2_mcase_reg <= s1_mcase_reg;
        s2_hit_reg   <= s1_hit_reg;
        s2_outer_reg <= s1_outer_reg;
        s2_src_reg   <= s1_src_reg;
    end

    assign s3_dot_next = {{2{s2_p_reg[0][31]}}, s2_p_reg[0]}
                       + {{2{s2_p_reg[1][31]}}, s2_p_reg[1]}
                       + {{2{s2_p_reg[2][31]}}, s2_p_reg[2]};
    assign s3_wsh_next = s2_wprod_reg[31:15];

    // flip the normal for a hit from behind
    always_ff @(posedge clk)
    begin
        s3_front_reg <= s3_dot_next[33];
        s3_c1mag_reg <= s3_dot_next[33] ? 32'(-s3_dot_next) : s3_dot_next[31:0];
        for (int i = 0; i < 3; i++)
        begin
            s3_np_reg[i] <= s3_dot_next[33] ? {s2_n_reg[i][15], s2_n_reg[i]}
                                            : 17'(-{s2_n_reg[i][15], s2_n_reg[i]});
        end
        s3_wout_reg  <= (s3_wsh_next > {1'b0, rdu_pkg::WEIGHT_ONE})
                        ? rdu_pkg::WEIGHT_ONE : s3_wsh_next[15:0];
        s3_d_reg     <= s2_d_reg;
        s3_mcase_reg <= s2_mcase_reg;
        s3_hit_reg   <= s2_hit_reg;
        s3_outer_reg <= s2_outer_reg;
        s3_src_reg   <= s2_src_reg;
    end

    always_comb
    begin
        logic [15:0] den_raw;
        if (s3_mcase_reg == rdu_pkg::MC_OUTSIDE)
        begin
            div_num = rdu_pkg::ONE_Q13;
            den_raw = s3_hit_reg;
        end
        else if (s3_mcase_reg == rdu_pkg::MC_INSIDE_HIT || !s3_front_reg)
        begin
            div_num = s3_hit_reg;
            den_raw = (s3_outer_reg != 16'd0) ? s3_outer_reg : rdu_pkg::ONE_Q13;
        end
        else
        begin
            div_num = (s3_outer_reg != 16'd0) ? s3_outer_reg : s3_src_reg;
            den_raw = s3_hit_reg;
        end
        div_den = (den_raw == 16'd0) ? 16'd1 : den_raw;
    end

    rdu_div u_div (
        .clk  (clk),
        .num  (div_num),
        .den  (div_den),
        .quot (div_quot)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            refl_prod_reg[i] <= $signed({1'b0, s3_c1mag_reg}) * $signed(s3_np_reg[i]);
        end
    end

    // reflected direction: d + round(2*c1*n / 2^(2F)), saturated
    always_comb
    begin
        logic signed [RFL_W-1:0] ext;
        logic signed [RFL_W-1:0] tot;
        for (int i = 0; i < 3; i++)
        begin
            ext = {{(RFL_W - 50){refl_prod_reg[i][49]}}, refl_prod_reg[i]};
            ext = ext <<< 1;
            tot = (ext + $signed(RFL_RND)) >>> (2 * VEC_FRAC_BITS);
            tot = tot + {{(RFL_W - 16){side_reg[0].d[i][15]}}, side_reg[0].d[i]};
            if (!tot[RFL_W-1] && (|tot[RFL_W-2:15]))
            begin
                refl_val[i] = 16'h7FFF;
            end
            else if (tot[RFL_W-1] && !(&tot[RFL_W-2:15]))
            begin
                refl_val[i] = 16'h8000;
            end
            else
            begin
                refl_val[i] = tot[15:0];
            end
        end
    end

    assign w_full    = div_quot * side_reg[IDX_ETA-1].c1;
    assign prod_next = ($signed({2'b00, side_reg[IDX_ETA].w})
                        - $signed({5'b00000, side_reg[IDX_ETA].eta}))
                     * ($signed({2'b00, side_reg[IDX_ETA].w})
                        + $signed({5'b00000, side_reg[IDX_ETA].eta}));
    assign c2_full   = (prod_reg >>> 16) + 48'sd65536;

    always_comb
    begin
        logic [31:0] c1_sh;
        c1_sh = s3_c1mag_reg >> C1_SH;
        side_next[0].d         = s3_d_reg;
        side_next[0].np        = s3_np_reg;
        side_next[0].refl      = '0;
        side_next[0].wout      = s3_wout_reg;
        side_next[0].c1        = (c1_sh > 32'h7FFFF) ? 19'h7FFFF : c1_sh[18:0];
        side_next[0].eta       = '0;
        side_next[0].w         = '0;
        side_next[0].refr      = 1'b0;
        side_next[0].flag_tir  = (s3_mcase_reg == rdu_pkg::MC_OUTSIDE);
        if (s3_mcase_reg == rdu_pkg::MC_OUTSIDE)
        begin
            side_next[0].flag_refr = 1'b0;
        end
        else if (s3_mcase_reg == rdu_pkg::MC_INSIDE_HIT)
        begin
            side_next[0].flag_refr = (s3_outer_reg == 16'd0);
        end
        else
        begin
            side_next[0].flag_refr = !s3_front_reg;
        end
        for (int k = 1; k < SIDE_LEN; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[1].refl      = refl_val;
        side_next[IDX_ETA].eta = div_quot;
        side_next[IDX_ETA].w   = w_full[37:16];
        side_next[IDX_C2].refr = !c2_full[47];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SIDE_LEN; k++)
        begin
            side_reg[k] <= side_next[k];
        end
        prod_reg <= prod_next;
        c2_reg   <= c2_full[C2_W-1:0];
    end

    rdu_sqrt u_sqrt (
        .clk  (clk),
        .c2   (c2_reg),
        .root (sq_root)
    );

    always_comb
    begin
        logic signed [23:0] ws;
        ws = $signed({2'b00, side_reg[IDX_SQ].w}) - $signed({1'b0, sq_root});
        for (int i = 0; i < 3; i++)
        begin
            m1_next[i] = $signed({1'b0, side_reg[IDX_SQ].eta}) * $signed(side_reg[IDX_SQ].d[i]);
            m2_next[i] = ws * $signed(side_reg[IDX_SQ].np[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next;
        m2_reg <= m2_next;
    end

    // refracted direction: round half up by 2^16, saturated
    always_comb
    begin
        logic signed [41:0] sum;
        logic signed [41:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sum = {{6{m1_reg[i][35]}}, m1_reg[i]} + {m2_reg[i][40], m2_reg[i]} + 42'sd32768;
            sh  = sum >>> 16;
            if (!sh[41] && (|sh[40:15]))
            begin
                refr_val[i] = 16'h7FFF;
            end
            else if (sh[41] && !(&sh[40:15]))
            begin
                refr_val[i] = 16'h8000;
            end
            else
            begin
                refr_val[i] = sh[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (side_reg[IDX_F1].refr)
        begin
            dir_out_reg    <= refr_val;
            weight_out_reg <= side_reg[IDX_F1].wout;
            kind_reg       <= 1'b0;
            outside_reg    <= side_reg[IDX_F1].flag_refr;
        end
        else
        begin
            dir_out_reg    <= side_reg[IDX_F1].refl;
            weight_out_reg <= rdu_pkg::WEIGHT_ONE;
            kind_reg       <= 1'b1;
            outside_reg    <= side_reg[IDX_F1].flag_tir;
        end
    end

    assign done        = done_reg;
    assign new_dir_x   = dir_out_reg[0];
    assign new_dir_y   = dir_out_reg[1];
    assign new_dir_z   = dir_out_reg[2];
    assign new_weight  = weight_out_reg;
    assign ray_kind    = kind_reg;
    assign now_outside = outside_reg;

endmodule

// ===== hw/rtl/rdu_checker.sv =====
// Port-level checks for the refraction direction unit, bound to the top level.
module rdu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  medium_case,
    input logic        done,
    input logic [15:0] new_weight,
    input logic        ray_kind,
    input logic        now_outside
);

    localparam int LAT = rdu_pkg::LATENCY;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted transaction");

    a_tir_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ray_kind) |->
            (new_weight == rdu_pkg::WEIGHT_ONE)
            && (now_outside == ($past(medium_case, LAT) == rdu_pkg::MC_OUTSIDE)))
        else $error("reflected result has wrong weight or flag");

    a_refr_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ray_kind && ($past(medium_case, LAT) == rdu_pkg::MC_OUTSIDE))
            |-> !now_outside)
        else $error("refraction from outside left the ray outside");

endmodule

bind refraction_direction_unit rdu_checker u_rdu_checker (.*);
